// ===== src/dpcb_pkg.sv =====
// ----------------------------------------------------------------------------
// dpcb_pkg: shared definitions for the dark pixel crop box unit
// Register indexes, trim level codes, thresholds and inset reciprocals.
// ----------------------------------------------------------------------------
package dpcb_pkg;

	// default frame limits
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int TRIM_W     = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIM_LEVEL   = 2'd2;

	// register reset values
	localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 13'd4096;
	localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 13'd4096;
	localparam logic [TRIM_W-1:0]     RST_TRIM_LEVEL   = 3'd2;

	// trim level codes with their own behavior, all others act as the default
	localparam logic [TRIM_W-1:0] TRIM_LIGHT  = 3'd1;
	localparam logic [TRIM_W-1:0] TRIM_MEDIUM = 3'd3;
	localparam logic [TRIM_W-1:0] TRIM_HEAVY  = 3'd4;

	localparam logic [7:0] THR_LIGHT   = 8'd250;
	localparam logic [7:0] THR_DEFAULT = 8'd234;
	localparam logic [7:0] THR_MEDIUM  = 8'd210;
	localparam logic [7:0] THR_HEAVY   = 8'd190;

	// floor(w/50) and floor(w/20) as (w * recip) >> INSET_SHIFT, exact for w < 40000
	localparam int          INSET_SHIFT = 20;
	localparam logic [31:0] RECIP_DIV50 = 32'd20972;
	localparam logic [31:0] RECIP_DIV20 = 32'd52429;

	// smallest crop dimension and width rounding step
	localparam int MIN_DIM = 4;

	// dark threshold for a trim level
	function automatic logic [7:0] level_threshold(input logic [TRIM_W-1:0] level);
		logic [7:0] thr;
		case (level)
			TRIM_LIGHT:  thr = THR_LIGHT;
			TRIM_MEDIUM: thr = THR_MEDIUM;
			TRIM_HEAVY:  thr = THR_HEAVY;
			default:     thr = THR_DEFAULT;
		endcase
		return thr;
	endfunction

endpackage

// ===== src/dark_pixel_crop_box_unit.sv =====
// ----------------------------------------------------------------------------
// dark_pixel_crop_box_unit: streaming auto-crop bounding box
// Tracks the box of dark pixels in a raster frame and emits one crop
// rectangle after the last pixel of each frame.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while in_stall is low, with no gaps needed
// between frames; the position counters and the dark-pixel box are updated in
// a single register stage. At the last pixel of a frame the finished box
// moves into a three-stage result pipeline (inset and divide, clamp, rounding
// and floors) whose last stage is the output register that drives the crop
// rectangle. The output register holds a result while out_stall is high;
// pixels keep flowing until the last pixel of a frame finds all three result
// stages occupied, and only then is in_stall raised.
module dark_pixel_crop_box_unit
	import dpcb_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// pixel input
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            pixel,
	// crop rectangle output
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [11:0]           rect_x,
	output logic [11:0]           rect_y,
	output logic [12:0]           rect_w,
	output logic [12:0]           rect_h,
	output logic                  full_image
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int SZW = (CFG_DATA_W > CW + 1) ? CFG_DATA_W : CW + 1;
	localparam int SZH = (CFG_DATA_W > RW + 1) ? CFG_DATA_W : RW + 1;
	localparam logic [SZW-1:0] MAXW_V = SZW'(MAX_WIDTH);
	localparam logic [SZH-1:0] MAXH_V = SZH'(MAX_HEIGHT);
	// reciprocal product width and vertical clamp width
	localparam int PW = INSET_SHIFT + CW + 1;
	localparam int VW = ((CW > RW) ? CW : RW) + 2;

	// configuration registers
	logic [CFG_DATA_W-1:0] image_width_q;
	logic [CFG_DATA_W-1:0] image_height_q;
	logic [TRIM_W-1:0]     trim_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
			trim_level_q   <= RST_TRIM_LEVEL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				CFG_TRIM_LEVEL:   trim_level_q   <= cfg_data[TRIM_W-1:0];
				default: ;
			endcase
		end
	end

	// effective frame size: zero acts as one, saturate at the maximum
	logic [SZW-1:0] width_ext;
	logic [SZH-1:0] height_ext;
	logic [CW:0]    frame_w;
	logic [RW:0]    frame_h;

	always_comb begin
		width_ext  = SZW'(image_width_q);
		height_ext = SZH'(image_height_q);
		if (width_ext == '0)
			frame_w = (CW+1)'(1);
		else if (width_ext > MAXW_V)
			frame_w = (CW+1)'(MAX_WIDTH);
		else
			frame_w = width_ext[CW:0];
		if (height_ext == '0)
			frame_h = (RW+1)'(1);
		else if (height_ext > MAXH_V)
			frame_h = (RW+1)'(MAX_HEIGHT);
		else
			frame_h = height_ext[RW:0];
	end

	// pipeline flow control
	logic s1_valid, s2_valid, s3_valid, out_valid_s4;
	logic s1_last, s1_fire, s1_free, s2_free, s3_free, out_free, in_xfer;

	assign out_free = !out_valid_s4 || !out_stall;
	assign s3_free  = !s3_valid || out_free;
	assign s2_free  = !s2_valid || s3_free;
	assign s1_fire  = s1_valid && (!s1_last || s2_free);
	assign s1_free  = !s1_valid || s1_fire;
	assign in_stall = !s1_free;
	assign in_xfer  = in_valid && !in_stall;

	// input register
	logic [7:0] pixel_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else if (s1_free)
			s1_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			pixel_s1 <= pixel;
	end

	// position counters and dark box
	logic [CW-1:0] col_q, left_q, right_q;
	logic [RW-1:0] row_q, top_q, bottom_q;
	logic          dark_seen_q;
	logic [CW:0]   col_inc;
	logic [RW:0]   row_inc;
	logic          col_end, row_end, is_dark;
	logic [CW-1:0] left_nx, right_nx;
	logic [RW-1:0] top_nx, bottom_nx;

	always_comb begin
		col_inc   = {1'b0, col_q} + {{CW{1'b0}}, 1'b1};
		row_inc   = {1'b0, row_q} + {{RW{1'b0}}, 1'b1};
		col_end   = col_inc >= frame_w;
		row_end   = row_inc >= frame_h;
		s1_last   = col_end && row_end;
		is_dark   = pixel_s1 <= level_threshold(trim_level_q);
		left_nx   = left_q;
		right_nx  = right_q;
		top_nx    = top_q;
		bottom_nx = bottom_q;
		if (is_dark) begin
			if (!dark_seen_q) begin
				left_nx  = col_q;
				right_nx = col_q;
				top_nx   = row_q;
			end else begin
				if (col_q < left_q)
					left_nx = col_q;
				if (col_q > right_q)
					right_nx = col_q;
			end
			bottom_nx = row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			left_q      <= '1;
			right_q     <= '0;
			top_q       <= '0;
			bottom_q    <= '0;
			dark_seen_q <= 1'b0;
		end else if (s1_fire) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_inc[RW-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
			if (s1_last) begin
				left_q      <= '1;
				right_q     <= '0;
				top_q       <= '0;
				bottom_q    <= '0;
				dark_seen_q <= 1'b0;
			end else begin
				left_q      <= left_nx;
				right_q     <= right_nx;
				top_q       <= top_nx;
				bottom_q    <= bottom_nx;
				dark_seen_q <= dark_seen_q || is_dark;
			end
		end
	end

	// inset size from the trim level, constant division by reciprocal
	logic [PW-1:0] prod_div50, prod_div20;
	logic [CW:0]   inset;

	always_comb begin
		prod_div50 = PW'(frame_w) * PW'(RECIP_DIV50);
		prod_div20 = PW'(frame_w) * PW'(RECIP_DIV20);
		case (trim_level_q)
			TRIM_MEDIUM: inset = prod_div50[INSET_SHIFT +: CW+1];
			TRIM_HEAVY:  inset = prod_div20[INSET_SHIFT +: CW+1];
			default:     inset = '0;
		endcase
	end

	// stage 2: finished box of the frame
	logic [CW-1:0] left_s2, right_s2;
	logic [RW-1:0] top_s2, bottom_s2;
	logic          dark_s2;
	logic [CW:0]   inset_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_valid <= 1'b0;
		else if (s2_free)
			s2_valid <= s1_fire && s1_last;
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_fire && s1_last) begin
			left_s2   <= left_nx;
			right_s2  <= right_nx;
			top_s2    <= top_nx;
			bottom_s2 <= bottom_nx;
			dark_s2   <= dark_seen_q || is_dark;
			inset_s2  <= inset;
		end
	end

	// shrink the box by the inset without letting it invert
	logic [CW:0]   left_ins, right_lim;
	logic [VW-1:0] top_ins, bottom_lim;
	logic [CW-1:0] left_cl, right_cl;
	logic [RW-1:0] top_cl, bottom_cl;

	always_comb begin
		left_cl    = left_s2;
		right_cl   = right_s2;
		top_cl     = top_s2;
		bottom_cl  = bottom_s2;
		left_ins   = {1'b0, left_s2} + inset_s2;
		right_lim  = '0;
		top_ins    = VW'(top_s2) + VW'(inset_s2);
		bottom_lim = '0;
		if (dark_s2 && inset_s2 != '0) begin
			left_cl = (left_ins < {1'b0, right_s2}) ? left_ins[CW-1:0] : right_s2;
			right_lim = {1'b0, left_cl} + inset_s2;
			right_cl = ({1'b0, right_s2} > right_lim) ?
				CW'({1'b0, right_s2} - inset_s2) : left_cl;
			top_cl = (top_ins < VW'(bottom_s2)) ? top_ins[RW-1:0] : bottom_s2;
			bottom_lim = VW'(top_cl) + VW'(inset_s2);
			bottom_cl = (VW'(bottom_s2) > bottom_lim) ?
				RW'(VW'(bottom_s2) - VW'(inset_s2)) : top_cl;
		end
	end

	// stage 3: clamped box
	logic [CW-1:0] left_s3, right_s3;
	logic [RW-1:0] top_s3, bottom_s3;
	logic          dark_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s3_valid <= 1'b0;
		else if (s3_free)
			s3_valid <= s2_valid;
	end

	always_ff @(posedge clk) begin
		if (s3_free && s2_valid) begin
			left_s3   <= left_cl;
			right_s3  <= right_cl;
			top_s3    <= top_cl;
			bottom_s3 <= bottom_cl;
			dark_s3   <= dark_s2;
		end
	end

	// rectangle: blank test, width rounding, floors
	logic          blank;
	logic [CW:0]   box_w;
	logic [CW+1:0] round_w, round_end, crop_w;
	logic [RW:0]   box_h, crop_h;
	logic [31:0]   x_full, y_full, w_full, h_full;

	always_comb begin
		blank = !dark_s3 || ({1'b0, left_s3} >= frame_w) || (right_s3 == '0) ||
			({1'b0, top_s3} >= frame_h) || (bottom_s3 < top_s3);
		box_w     = {1'b0, right_s3} - {1'b0, left_s3} + {{CW{1'b0}}, 1'b1};
		round_w   = {1'b0, box_w[CW:2], 2'b00} + (CW+2)'(MIN_DIM);
		round_end = round_w + (CW+2)'(left_s3);
		crop_w    = (round_end > (CW+2)'(frame_w)) ? round_w - (CW+2)'(MIN_DIM) : round_w;
		if (crop_w < (CW+2)'(MIN_DIM))
			crop_w = (CW+2)'(MIN_DIM);
		box_h  = {1'b0, bottom_s3} - {1'b0, top_s3} + {{RW{1'b0}}, 1'b1};
		crop_h = (box_h < (RW+1)'(MIN_DIM)) ? (RW+1)'(MIN_DIM) : box_h;
		if (blank) begin
			x_full = '0;
			y_full = '0;
			w_full = 32'(frame_w);
			h_full = 32'(frame_h);
		end else begin
			x_full = 32'(left_s3);
			y_full = 32'(top_s3);
			w_full = 32'(crop_w);
			h_full = 32'(crop_h);
		end
	end

	// output register
	logic [11:0] rect_x_s4, rect_y_s4;
	logic [12:0] rect_w_s4, rect_h_s4;
	logic        full_image_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_s4 <= 1'b0;
		else if (out_free)
			out_valid_s4 <= s3_valid;
	end

	always_ff @(posedge clk) begin
		if (out_free && s3_valid) begin
			rect_x_s4     <= x_full[11:0];
			rect_y_s4     <= y_full[11:0];
			rect_w_s4     <= w_full[12:0];
			rect_h_s4     <= h_full[12:0];
			full_image_s4 <= blank;
		end
	end

	assign out_valid  = out_valid_s4;
	assign rect_x     = rect_x_s4;
	assign rect_y     = rect_y_s4;
	assign rect_w     = rect_w_s4;
	assign rect_h     = rect_h_s4;
	assign full_image = full_image_s4;

	// input is held back only by an occupied input register
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid)
		else $error("input stalled with empty input register");

	// a captured dark box is never inverted
	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid && dark_s2) |-> (left_s2 <= right_s2 && top_s2 <= bottom_s2))
		else $error("frame box inverted at capture");

	// the inset clamp keeps the box ordered
	a_clamp_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(s3_valid && dark_s3) |-> (left_s3 <= right_s3 && top_s3 <= bottom_s3))
		else $error("inset clamp inverted the box");

	// a result enters the output only from a filled clamp stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid)) |-> $past(s3_valid))
		else $error("result appeared without a finished frame");

endmodule

// ===== tb/tb_dark_pixel_crop_box_unit.sv =====
// ----------------------------------------------------------------------------
// tb_dark_pixel_crop_box_unit: self-checking bench for the crop box unit
// Streams greyscale frames under many sizes and trim levels, with random
// gaps and stalls on both channels, and checks every crop rectangle against
// a cycle-free model of the dark-pixel bounding box and its crop rules.
// ----------------------------------------------------------------------------
module tb_dark_pixel_crop_box_unit;
	import dpcb_pkg::*;

	// cycles to let the result pipeline settle before a register write
	localparam int LAT_SLACK   = 8;
	localparam int DRAIN_LIMIT = 100000;
	// highest trim code, acts as the default level
	localparam logic [TRIM_W-1:0] TRIM_TOP_CODE = 3'd7;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [12:0] w;
		logic [12:0] h;
		logic        full;
	} crop_rect_t;

	typedef enum int {STYLE_BLANK, STYLE_SPARSE, STYLE_NEAR, STYLE_UNIFORM} pixel_style_t;

	// model of the frame position, the dark box and the crop result
	class crop_rect_scoreboard;
		logic [CFG_DATA_W-1:0] width_reg;
		logic [CFG_DATA_W-1:0] height_reg;
		logic [TRIM_W-1:0]     trim_reg;
		int col, row;
		int box_l, box_r, box_t, box_b;
		bit dark_seen;
		crop_rect_t pending_rects[$];
		int rect_errors;

		function new();
			width_reg = RST_IMAGE_WIDTH;
			height_reg = RST_IMAGE_HEIGHT;
			trim_reg = RST_TRIM_LEVEL;
			col = 0;
			row = 0;
			rect_errors = 0;
			clear_box();
		endfunction

		function void clear_box();
			box_l = 'h1FFF;
			box_r = 0;
			box_t = 0;
			box_b = 0;
			dark_seen = 1'b0;
		endfunction

		// zero acts as one, oversize saturates
		function int clamp_dim(int v, int lim);
			if (v == 0)
				return 1;
			if (v > lim)
				return lim;
			return v;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_IMAGE_WIDTH:  width_reg = val;
				CFG_IMAGE_HEIGHT: height_reg = val;
				CFG_TRIM_LEVEL:   trim_reg = val[TRIM_W-1:0];
				default: ;
			endcase
		endfunction

		// pixels still needed to close the current frame
		function int pixels_to_frame_end();
			int w, h, c;
			w = clamp_dim(width_reg, DEF_MAX_WIDTH);
			h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
			c = (col < w) ? col : w - 1;
			if (row + 1 >= h)
				return w - c;
			return w - c + (h - row - 1) * w;
		endfunction

		// one accepted pixel transfer
		function void take_pixel(logic [7:0] value);
			int w, h, c, r, ins, l, rt, t, b, wd, ntw, ht;
			logic [7:0] thr;
			crop_rect_t rect;
			w = clamp_dim(width_reg, DEF_MAX_WIDTH);
			h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
			c = col;
			r = row;
			case (trim_reg)
				TRIM_LIGHT:  thr = THR_LIGHT;
				TRIM_MEDIUM: thr = THR_MEDIUM;
				TRIM_HEAVY:  thr = THR_HEAVY;
				default:     thr = THR_DEFAULT;
			endcase

			// widen the dark box
			if (value <= thr) begin
				if (!dark_seen) begin
					dark_seen = 1'b1;
					box_t = r;
					box_l = c;
					box_r = c;
				end else begin
					if (c < box_l)
						box_l = c;
					if (c > box_r)
						box_r = c;
				end
				box_b = r;
			end

			// advance position, close the frame on its last pixel
			if (c + 1 >= w) begin
				col = 0;
				if (r + 1 >= h) begin
					ins = 0;
					if (trim_reg == TRIM_MEDIUM)
						ins = w / 50;
					else if (trim_reg == TRIM_HEAVY)
						ins = w / 20;
					l = box_l;
					rt = box_r;
					t = box_t;
					b = box_b;
					if (dark_seen && ins > 0) begin
						l = (l + ins < rt) ? l + ins : rt;
						rt = (rt - ins > l) ? rt - ins : l;
						t = (t + ins < b) ? t + ins : b;
						b = (b - ins > t) ? b - ins : t;
					end
					if (!dark_seen || l >= w || rt <= 0 || t >= h || b < t) begin
						rect = '{12'd0, 12'd0, w[12:0], h[12:0], 1'b1};
					end else begin
						wd = rt - l + 1;
						ht = b - t + 1;
						ntw = wd + 4 - wd % 4;
						if (ntw < 0)
							ntw = 0;
						if (ntw + l > w)
							ntw -= 4;
						if (ntw < MIN_DIM)
							ntw = MIN_DIM;
						if (ht < MIN_DIM)
							ht = MIN_DIM;
						rect = '{l[11:0], t[11:0], ntw[12:0], ht[12:0], 1'b0};
					end
					pending_rects.push_back(rect);
					row = 0;
					clear_box();
				end else begin
					row = r + 1;
				end
			end else begin
				col = c + 1;
			end
		endfunction

		// one accepted rectangle transfer against the oldest expectation
		function void check_rect(crop_rect_t got);
			crop_rect_t want;
			if (pending_rects.size() == 0) begin
				rect_errors++;
				if (rect_errors <= 10)
					$display("rect error: unexpected x=%0d y=%0d w=%0d h=%0d full=%0b",
						got.x, got.y, got.w, got.h, got.full);
				return;
			end
			want = pending_rects.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
					got.h !== want.h || got.full !== want.full) begin
				rect_errors++;
				if (rect_errors <= 10) begin
					$write("rect error: expected x=%0d y=%0d w=%0d h=%0d full=%0b, ",
						want.x, want.y, want.w, want.h, want.full);
					$display("got x=%0d y=%0d w=%0d h=%0d full=%0b",
						got.x, got.y, got.w, got.h, got.full);
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [7:0]            pixel;
	logic                  out_valid;
	logic                  out_stall;
	logic [11:0]           rect_x;
	logic [11:0]           rect_y;
	logic [12:0]           rect_w;
	logic [12:0]           rect_h;
	logic                  full_image;

	crop_rect_scoreboard sb = new();
	int send_idle_pct = 9;
	int recv_idle_pct = 63;
	int hold_cycles = 0;
	int pixels_sent = 0;

	// directed frames
	logic [7:0] single_px [4] = '{8'd250, 8'd251, 8'd0, 8'd255};
	logic [7:0] box_px [12] = '{8'd255, 8'd234, 8'd235, 8'd255,
		8'd255, 8'd255, 8'd0, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd128};
	logic [7:0] heavy_px [4] = '{8'd191, 8'd255, 8'd255, 8'd190};

	dark_pixel_crop_box_unit uut (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver stalls, with an optional long hold-off
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_rect('{rect_x, rect_y, rect_w, rect_h, full_image});
	end

	// run limit
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// one pixel transfer, with random gaps ahead of it
	task automatic send_pixel(input logic [7:0] value);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.take_pixel(value);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic send_pixels(input int count, input pixel_style_t style);
		logic [7:0] value;
		repeat (count) begin
			case (style)
				STYLE_BLANK:  value = 8'($urandom_range(251, 255));
				STYLE_SPARSE: value = ($urandom_range(0, 11) == 0) ?
					8'($urandom_range(0, 189)) : 8'($urandom_range(251, 255));
				STYLE_NEAR:   value = 8'($urandom_range(185, 255));
				default:      value = 8'($urandom_range(0, 255));
			endcase
			send_pixel(value);
		end
	endtask

	function automatic pixel_style_t pick_style();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return STYLE_BLANK;
		if (roll < 6)
			return STYLE_SPARSE;
		if (roll < 8)
			return STYLE_NEAR;
		return STYLE_UNIFORM;
	endfunction

	// sender pauses until every rectangle is back and the pipeline is empty
	task automatic wait_idle();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (sb.pending_rects.size() != 0 && guard < DRAIN_LIMIT) begin
			@(negedge clk);
			guard++;
		end
		repeat (LAT_SLACK)
			@(negedge clk);
	endtask

	// write all three registers while idle
	task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
			input logic [TRIM_W-1:0] trim);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= w;
		@(negedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data <= h;
		@(negedge clk);
		cfg_index <= CFG_TRIM_LEVEL;
		cfg_data <= {{(CFG_DATA_W-TRIM_W){1'b0}}, trim};
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(CFG_IMAGE_WIDTH, w);
		sb.write_reg(CFG_IMAGE_HEIGHT, h);
		sb.write_reg(CFG_TRIM_LEVEL, {{(CFG_DATA_W-TRIM_W){1'b0}}, trim});
	endtask

	// mostly small frames, some wide enough for the insets, a few zero sizes
	task automatic configure_random();
		int roll, w, h;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			w = 0;
		else if (roll < 20)
			w = $urandom_range(20, 60);
		else
			w = $urandom_range(1, 12);
		h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
		configure(CFG_DATA_W'(w), CFG_DATA_W'(h), TRIM_W'($urandom_range(0, 7)));
	endtask

	// main sequence
	initial begin
		int frames;
		int start_px;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel = 8'd0;
		repeat (5)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// one-pixel frames around the light threshold, dark at column zero
		configure(13'd0, 13'd0, TRIM_LIGHT);
		foreach (single_px[i])
			send_pixel(single_px[i]);
		// small box at the default threshold
		configure(13'd4, 13'd3, RST_TRIM_LEVEL);
		foreach (box_px[i])
			send_pixel(box_px[i]);
		// heavy threshold, width rounding past the right edge and floors
		configure(13'd2, 13'd2, TRIM_HEAVY);
		foreach (heavy_px[i])
			send_pixel(heavy_px[i]);

		// long receiver hold-off while one-pixel frames keep coming
		configure(13'd1, 13'd1, TRIM_MEDIUM);
		@(posedge clk);
		hold_cycles = 300;
		@(negedge clk);
		send_pixels(40, STYLE_UNIFORM);

		// size extremes: a saturated and an exact maximum row, closed by a shrink
		configure(13'd8191, 13'd1, TRIM_HEAVY);
		send_pixels(50, STYLE_SPARSE);
		configure(13'd20, 13'd1, TRIM_HEAVY);
		send_pixels(sb.pixels_to_frame_end(), STYLE_SPARSE);
		configure(RST_IMAGE_WIDTH, 13'd1, TRIM_MEDIUM);
		send_pixels(30, STYLE_SPARSE);
		configure(13'd40, 13'd1, TRIM_MEDIUM);
		send_pixels(sb.pixels_to_frame_end(), STYLE_SPARSE);
		// full height column at the top trim code, closed by a shrink
		configure(13'd1, RST_IMAGE_HEIGHT, TRIM_TOP_CODE);
		send_pixels(30, STYLE_SPARSE);
		configure(13'd1, 13'd2, TRIM_TOP_CODE);
		send_pixels(sb.pixels_to_frame_end(), STYLE_SPARSE);

		// random frames in three idle patterns
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 9 : (mode == 1) ? 63 : 0;
			recv_idle_pct = (mode == 0) ? 63 : (mode == 1) ? 9 : 0;
			frames = 0;
			start_px = pixels_sent;
			while (frames < 3 || pixels_sent - start_px < 120) begin
				if (frames == 0 || $urandom_range(0, 3) == 0)
					configure_random();
				// broken frame: size or level changed partway through
				if ($urandom_range(0, 9) == 0 && sb.pixels_to_frame_end() > 1) begin
					send_pixels($urandom_range(1, sb.pixels_to_frame_end() - 1), pick_style());
					configure_random();
				end
				send_pixels(sb.pixels_to_frame_end(), pick_style());
				frames++;
			end
		end

		wait_idle();
		sb.rect_errors += sb.pending_rects.size();
		if (sb.rect_errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
